[sv/csi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csi_pkg;

   // Default coordinate width; the radius is one bit narrower.
   localparam int COORD_BITS_DEFAULT = 16;

   // Clock edges from the edge that accepts a transaction to the edge that
   // samples its result strobe.
   localparam int PIPE_DEPTH = 7;

endpackage

`default_nettype wire

[sv/csi_split_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Unsigned WIDTH x WIDTH multiplier, cut into four half-width partial
// products in the first stage and summed in the second.
module csi_split_mul #(
   parameter int WIDTH = 34
) (
   input  wire logic                   clock,
   input  wire logic [WIDTH-1:0]       x,
   input  wire logic [WIDTH-1:0]       y,
   output logic      [2*WIDTH-1:0]     prod
);

   localparam int HALF = (WIDTH + 1) / 2;
   localparam int PRW  = 4 * HALF;

   logic [2*HALF-1:0] x_ext;
   logic [2*HALF-1:0] y_ext;
   logic [2*HALF-1:0] pp_ll_ff;
   logic [2*HALF-1:0] pp_lh_ff;
   logic [2*HALF-1:0] pp_hl_ff;
   logic [2*HALF-1:0] pp_hh_ff;
   logic [PRW-1:0]    sum_in;
   logic [2*WIDTH-1:0] prod_ff;

   assign x_ext = (2*HALF)'(x);
   assign y_ext = (2*HALF)'(y);

   // Stage one: the four half-width partial products.
   always_ff @(posedge clock) begin
      pp_ll_ff <= x_ext[HALF-1:0]      * y_ext[HALF-1:0];
      pp_lh_ff <= x_ext[HALF-1:0]      * y_ext[2*HALF-1:HALF];
      pp_hl_ff <= x_ext[2*HALF-1:HALF] * y_ext[HALF-1:0];
      pp_hh_ff <= x_ext[2*HALF-1:HALF] * y_ext[2*HALF-1:HALF];
   end

   // Stage two: shift the partial products into place and add them.
   always_comb begin
      sum_in = (PRW'(pp_hh_ff) << (2*HALF))
             + ((PRW'(pp_lh_ff) + PRW'(pp_hl_ff)) << HALF)
             + PRW'(pp_ll_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= sum_in[2*WIDTH-1:0];
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

[sv/circle_segment_intersect.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel      Ports                                   Handshake
// request      req_seg_*, req_circle_*                 start high, busy low
// response     rsp_hit                                 rsp_valid strobe, one cycle
//
// A transaction is accepted in every cycle; busy is never raised.
// Seven register stages: differences, products, sums, endpoint tests, two
// stages of the split wide multiplier for h^2 and a*c, and the final compare.
// Synchronous reset clears the valid bits of every stage.
// The receiver cannot stall, so the pipeline always advances.
module circle_segment_intersect #(
   parameter int COORD_BITS = csi_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_BITS-1:0]  req_seg_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_seg_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_seg_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_seg_end_y,
   input  wire logic signed [COORD_BITS-1:0]  req_circle_center_x,
   input  wire logic signed [COORD_BITS-1:0]  req_circle_center_y,
   input  wire logic        [COORD_BITS-2:0]  req_circle_radius,
   output logic                               rsp_valid,
   output logic                               rsp_hit
);

   localparam int DW = COORD_BITS + 1;         // coordinate differences
   localparam int PW = 2 * DW;                 // signed products
   localparam int RW = 2 * (COORD_BITS - 1);   // radius squared
   localparam int SW = 2 * COORD_BITS + 3;     // a, h, c and the end value
   localparam int UW = 2 * COORD_BITS + 2;     // magnitudes of a, c and -h

   // Stage 1: differences.
   logic                 v1_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, fx_ff, fy_ff, gx_ff, gy_ff;
   logic [COORD_BITS-2:0] r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= DW'(req_seg_end_x)   - DW'(req_seg_start_x);
      dy_ff <= DW'(req_seg_end_y)   - DW'(req_seg_start_y);
      fx_ff <= DW'(req_seg_start_x) - DW'(req_circle_center_x);
      fy_ff <= DW'(req_seg_start_y) - DW'(req_circle_center_y);
      gx_ff <= DW'(req_seg_end_x)   - DW'(req_circle_center_x);
      gy_ff <= DW'(req_seg_end_y)   - DW'(req_circle_center_y);
      r_ff  <= req_circle_radius;
   end

   // Stage 2: products.
   logic                 v2_ff;
   logic signed [PW-1:0] dxx_ff, dyy_ff, fdx_ff, fdy_ff, fxx_ff, fyy_ff, gxx_ff, gyy_ff;
   logic [RW-1:0]        rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dxx_ff <= PW'(dx_ff) * PW'(dx_ff);
      dyy_ff <= PW'(dy_ff) * PW'(dy_ff);
      fdx_ff <= PW'(fx_ff) * PW'(dx_ff);
      fdy_ff <= PW'(fy_ff) * PW'(dy_ff);
      fxx_ff <= PW'(fx_ff) * PW'(fx_ff);
      fyy_ff <= PW'(fy_ff) * PW'(fy_ff);
      gxx_ff <= PW'(gx_ff) * PW'(gx_ff);
      gyy_ff <= PW'(gy_ff) * PW'(gy_ff);
      rr_ff  <= RW'(r_ff) * RW'(r_ff);
   end

   // Stage 3: quadratic coefficients and the value at the segment end.
   logic                 v3_ff;
   logic signed [SW-1:0] a_ff, h_ff, c_ff, g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= SW'(dxx_ff) + SW'(dyy_ff);
      h_ff <= SW'(fdx_ff) + SW'(fdy_ff);
      c_ff <= $signed(SW'(fxx_ff) + SW'(fyy_ff) - SW'(rr_ff));
      g_ff <= $signed(SW'(gxx_ff) + SW'(gyy_ff) - SW'(rr_ff));
   end

   // Stage 4: endpoint tests and the operands of the vertex test.
   logic                 a_pos;
   logic                 c_zero, g_zero, c_neg, g_neg, h_nonpos;
   logic [SW-1:0]        mh_full;
   logic                 early_in, vertex_in;
   logic                 v4_ff, early4_ff, vertex4_ff;
   logic [UW-1:0]        mh4_ff, a4_ff, c4_ff;

   always_comb begin
      a_pos    = (a_ff != '0);
      c_zero   = (c_ff == '0);
      g_zero   = (g_ff == '0);
      c_neg    = c_ff[SW-1];
      g_neg    = g_ff[SW-1];
      h_nonpos = h_ff[SW-1] || (h_ff == '0);
      mh_full  = SW'(0) - h_ff;
      // A root sits at an endpoint or between the two ends.
      early_in  = a_pos && (c_zero || g_zero || (c_neg != g_neg));
      // Start outside, vertex within the segment: decided by h^2 >= a*c.
      vertex_in = a_pos && !c_neg && !c_zero && h_nonpos
               && (mh_full[UW-1:0] <= a_ff[UW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      early4_ff  <= early_in;
      vertex4_ff <= vertex_in;
      mh4_ff     <= mh_full[UW-1:0];
      a4_ff      <= a_ff[UW-1:0];
      c4_ff      <= c_ff[UW-1:0];
   end

   // Stages 5 and 6: wide products, flags delayed alongside.
   logic [2*UW-1:0] hh_prod, ac_prod;
   logic            v5_ff, v6_ff;
   logic            early5_ff, early6_ff, vertex5_ff, vertex6_ff;

   csi_split_mul #(.WIDTH(UW)) u_mul_hh (
      .clock (clock),
      .x     (mh4_ff),
      .y     (mh4_ff),
      .prod  (hh_prod)
   );

   csi_split_mul #(.WIDTH(UW)) u_mul_ac (
      .clock (clock),
      .x     (a4_ff),
      .y     (c4_ff),
      .prod  (ac_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      early5_ff  <= early4_ff;
      early6_ff  <= early5_ff;
      vertex5_ff <= vertex4_ff;
      vertex6_ff <= vertex5_ff;
   end

   // Stage 7: final decision into the result register.
   logic hit_in;
   logic rsp_valid_ff, rsp_hit_ff;

   assign hit_in = early6_ff || (vertex6_ff && (hh_prod >= ac_prod));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= hit_in;
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

`default_nettype wire

[sv/csi_check.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks of the intersection pipeline.
module csi_check #(
   parameter int COORD_BITS = csi_pkg::COORD_BITS_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic signed [COORD_BITS-1:0]  req_seg_start_x,
   input wire logic signed [COORD_BITS-1:0]  req_seg_start_y,
   input wire logic signed [COORD_BITS-1:0]  req_seg_end_x,
   input wire logic signed [COORD_BITS-1:0]  req_seg_end_y,
   input wire logic signed [COORD_BITS-1:0]  req_circle_center_x,
   input wire logic signed [COORD_BITS-1:0]  req_circle_center_y,
   input wire logic        [COORD_BITS-2:0]  req_circle_radius,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_hit
);

   // Every accepted transaction produces its result after the fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(csi_pkg::PIPE_DEPTH) rsp_valid)
      else $error("accepted transaction produced no result");

   // A result only ever answers a transaction accepted at the fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, csi_pkg::PIPE_DEPTH))
      else $error("result without a matching transaction");

   // A zero-length segment never reports a hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past((req_seg_start_x == req_seg_end_x)
                       && (req_seg_start_y == req_seg_end_y), csi_pkg::PIPE_DEPTH))
      |-> !rsp_hit)
      else $error("zero-length segment reported as a hit");

   // Reset flushes every transaction in flight.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind circle_segment_intersect csi_check #(.COORD_BITS(COORD_BITS)) u_csi_check (.*);

`default_nettype wire
